/* rtl/iwa_pkg.sv */
// ============================================================================
// iwa_pkg: shared types and constants of the IMU window averager
// Window geometry, datapath widths, the Z scaling reciprocal and the
// control state type.
// ============================================================================
package iwa_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int SAMPLE_W   = 16;
  localparam int DIV_W      = 11;
  localparam int DZ_W       = 11;
  localparam int SZ_W       = 10;

  // sum of a full window of 16-bit samples
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int DIVR_W = FILL_W + DIV_W;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  // |z| / 100 as (|z| * ceil(2^22 / 100)) >> 22, exact for |z| <= 32768
  localparam int Z_RECIP_W = 16;
  localparam int Z_SHIFT   = 22;
  localparam int PROD_W    = 32;
  localparam logic [Z_RECIP_W-1:0] Z_RECIP = 16'd41944;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PUSH,
    ST_DIV
  } iwa_state_e;

  typedef struct packed {
    logic                busy;
    logic [SAMPLE_W-1:0] quot;
  } iwa_lane_out_t;

endpackage

/* rtl/iwa_zscale.sv */
// ============================================================================
// iwa_zscale: Z scaling and differencing
// Divides the Z acceleration by 100 toward zero through a reciprocal
// multiply and forms the difference to the previous scaled value.
// ============================================================================
module iwa_zscale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic                                push_i,
  input  logic signed [iwa_pkg::SAMPLE_W-1:0] accel_z_i,
  output logic signed [iwa_pkg::DZ_W-1:0]     dz_o
);
  import iwa_pkg::*;

  logic [SAMPLE_W-1:0]      mag_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic signed [SZ_W-1:0]   prev_q;
  logic [SZ_W-1:0]          quot_mag;
  logic signed [SZ_W-1:0]   scaled;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q <= accel_z_i[SAMPLE_W-1];
      mag_q <= accel_z_i[SAMPLE_W-1] ? $unsigned(-accel_z_i) : $unsigned(accel_z_i);
    end
    prod_q <= PROD_W'(mag_q) * PROD_W'(Z_RECIP);
  end

  assign quot_mag = prod_q[Z_SHIFT +: SZ_W];
  assign scaled   = neg_q ? -$signed(quot_mag) : $signed(quot_mag);
  assign dz_o     = DZ_W'(scaled) - DZ_W'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (push_i) begin
      prev_q <= scaled;
    end
  end

endmodule

/* rtl/iwa_lane.sv */
// ============================================================================
// iwa_lane: one averaging lane
// Sliding window with running sum and fill count, followed by a
// restoring divider that takes one quotient bit per cycle.
// ============================================================================
module iwa_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [iwa_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [iwa_pkg::DIV_W-1:0]           extra_i,
  output iwa_pkg::iwa_lane_out_t              lane_o
);
  import iwa_pkg::*;

  logic signed [SAMPLE_W-1:0] win_q [WINDOW_LEN];
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SUM_W-1:0]    drop;
  logic                       full;
  logic                       load_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SUM_W-1:0]           mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic [DIVR_W-1:0]          divr_q, divr_d;
  logic [DIVR_W-1:0]          rem_q, rem_d;
  logic [DIVR_W:0]            trial;
  logic                       qbit;
  logic [SUM_W-1:0]           quot;

  assign full   = (fill_q == FILL_W'(WINDOW_LEN));
  assign drop   = full ? SUM_W'(win_q[WINDOW_LEN-1]) : '0;
  assign sum_d  = sum_q + SUM_W'(sample_i) - drop;
  assign fill_d = full ? fill_q : fill_q + 1'b1;

  // newest at the head, oldest drops off the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  assign trial = {rem_q, mag_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, divr_q});

  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    divr_d = divr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (load_q) begin
      neg_d  = sum_q[SUM_W-1];
      mag_d  = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
      divr_d = DIVR_W'(fill_q) * DIVR_W'(extra_i);
      rem_d  = '0;
      cnt_d  = CNT_W'(SUM_W);
    end else if (cnt_q != '0) begin
      rem_d = qbit ? DIVR_W'(trial - {1'b0, divr_q}) : trial[DIVR_W-1:0];
      mag_d = {mag_q[SUM_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    divr_q <= divr_d;
    rem_q  <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      load_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      load_q <= push_i;
      cnt_q  <= cnt_d;
      if (push_i) begin
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
    end
  end

  assign quot        = neg_q ? $unsigned(-mag_q) : mag_q;
  assign lane_o.quot = quot[SAMPLE_W-1:0];
  assign lane_o.busy = load_q || (cnt_q != '0);

endmodule

/* rtl/imu_window_averager_unit.sv */
// ============================================================================
// imu_window_averager_unit: sliding-window IMU averager
// Three lanes average X, Y and the Z delta; the top merges their results.
// ============================================================================
// Usage:
//   Input beats on s_axis carry accel_x, accel_y and world_accel_z; each beat
//   yields one output beat on m_axis with avg_x, avg_y and avg_z_delta.
//   cfg_we_i / cfg_wdata_i write position_divider (0 acts as 1); write it
//   only while the block is idle.
//   Sequence: the beat is registered, the Z reciprocal multiply is registered,
//   the windows are pushed, the dividers are loaded and run SUM_W divider
//   steps (19 at a window of eight), then the result enters the output
//   register once it is free and m_axis_tvalid rises.
//   A new beat is accepted only after the last one has left the bit-serial
//   dividers of the lanes, which all run in lockstep.
//   s_axis_tready is high only while no beat is in the lanes. A finished
//   result waits in the output register, so a new beat is accepted while
//   the receiver stalls; a second result waits in the lanes until it frees.
//   Reset empties the windows, clears the previous Z, sets the divider to 1.
// ============================================================================
module imu_window_averager_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iwa_pkg::DIV_W-1:0]     cfg_wdata_i,   // position_divider
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // accel_x, accel_y, world_accel_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata   // avg_x, avg_y, avg_z_delta, 5'b0
);
  import iwa_pkg::*;

  iwa_state_e                 state_q, state_d;
  logic [DIV_W-1:0]           pos_div_q;
  logic [DIV_W-1:0]           div_eff;
  logic signed [SAMPLE_W-1:0] in_x_q, in_y_q;
  logic signed [DZ_W-1:0]     dz;
  logic                       accept, push, out_load, out_free, lanes_busy;
  iwa_lane_out_t              lane_x, lane_y, lane_z;
  logic [SAMPLE_W-1:0]        out_x_q, out_y_q;
  logic [DZ_W-1:0]            out_z_q;
  logic                       out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_div_q <= DIV_W'(1);
    end else if (cfg_we_i) begin
      pos_div_q <= cfg_wdata_i;
    end
  end

  assign div_eff = (pos_div_q == '0) ? DIV_W'(1) : pos_div_q;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign lanes_busy = lane_x.busy || lane_y.busy || lane_z.busy;
  assign out_free   = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_DIV;
      ST_DIV:   if (!lanes_busy && out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    push          = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_PUSH:  push = 1'b1;
      ST_DIV:   out_load = !lanes_busy && out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_x_q <= s_axis_tdata[15:0];
      in_y_q <= s_axis_tdata[31:16];
    end
  end

  iwa_zscale u_zscale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .push_i    (push),
    .accel_z_i (s_axis_tdata[47:32]),
    .dz_o      (dz)
  );

  iwa_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (in_x_q),
    .extra_i  (div_eff),
    .lane_o   (lane_x)
  );

  iwa_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (in_y_q),
    .extra_i  (div_eff),
    .lane_o   (lane_y)
  );

  iwa_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (SAMPLE_W'(dz)),
    .extra_i  (DIV_W'(1)),
    .lane_o   (lane_z)
  );

  // merge the lane quotients into the output beat
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q <= lane_x.quot;
      out_y_q <= lane_y.quot;
      out_z_q <= lane_z.quot[DZ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_z_q, out_y_q, out_x_q};

`ifndef SYNTHESIS
  a_ready_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !lanes_busy)
    else $error("input ready while lanes busy");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_x.busy == lane_z.busy) && (lane_y.busy == lane_z.busy))
    else $error("lanes out of step");

  a_accept_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCALE))
    else $error("accepted beat not scaled");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (push == 1'b0) && out_free)
    else $error("output loaded while occupied");
`endif

endmodule
